>>> rtl/core/cve_pkg.sv
// ----------------------------------------------------------------------------
// Complex value extract package
// Shared widths, op codes, angle constants and the arctangent table.
// ----------------------------------------------------------------------------
package cve_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ANGLE_STEPS_DEF = 16;

	localparam int CORDIC_ITERS = 32;
	localparam int GUARD_BITS   = 24;
	localparam int PREP_STAGES  = 3;
	localparam int ANG_W        = 32;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 33;
	localparam int M_DATA_W = ((VALUE_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_REAL   = 3'd0,
		OP_IMAG   = 3'd1,
		OP_MAG    = 3'd2,
		OP_MAG_SQ = 3'd3,
		OP_PHASE  = 3'd4
	} op_t;

	localparam logic [ANG_W-1:0] ANG_ZERO    = 32'h0000_0000;
	localparam logic [ANG_W-1:0] ANG_QUARTER = 32'h4000_0000;
	localparam logic [ANG_W-1:0] ANG_HALF    = 32'h8000_0000;
	localparam logic [ANG_W-1:0] ANG_THREE_Q = 32'hC000_0000;

	// atan(2^-i) as a fraction of a full turn, scaled by 2^32.
	localparam logic [ANG_W-1:0] TURN_TABLE [CORDIC_ITERS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage

>>> rtl/core/cve_prep.sv
// ----------------------------------------------------------------------------
// Sample preparation
// Three stages: absolute values and vector set-up, squares, squared sum.
// ----------------------------------------------------------------------------
module cve_prep #(
	parameter int SAMPLE_BITS = cve_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [SAMPLE_BITS-1:0]          re_in,
	input  logic signed [SAMPLE_BITS-1:0]          im_in,
	output logic [2*SAMPLE_BITS-1:0]               sq_out,
	output logic signed [SAMPLE_BITS+cve_pkg::GUARD_BITS+2:0] x_out,
	output logic signed [SAMPLE_BITS+cve_pkg::GUARD_BITS+2:0] y_out,
	output logic [cve_pkg::ANG_W-1:0]              ang_out,
	output logic                                   byp_out
);

	localparam int N  = SAMPLE_BITS;
	localparam int XW = SAMPLE_BITS + cve_pkg::GUARD_BITS + 3;
	localparam int RW = 2 * SAMPLE_BITS;

	logic                       neg;
	logic [N-1:0]               re_u;
	logic [N-1:0]               im_u;
	logic [N-1:0]               are_d;
	logic [N-1:0]               aim_d;
	logic signed [XW-1:0]       rex;
	logic signed [XW-1:0]       imx;
	logic signed [XW-1:0]       x_d;
	logic signed [XW-1:0]       y_d;
	logic [cve_pkg::ANG_W-1:0]  ang_d;
	logic                       byp_d;

	logic [N-1:0]               are_s1;
	logic [N-1:0]               aim_s1;
	logic signed [XW-1:0]       x_s1;
	logic signed [XW-1:0]       y_s1;
	logic [cve_pkg::ANG_W-1:0]  ang_s1;
	logic                       byp_s1;

	logic [RW-1:0]              sqa_s2;
	logic [RW-1:0]              sqb_s2;
	logic signed [XW-1:0]       x_s2;
	logic signed [XW-1:0]       y_s2;
	logic [cve_pkg::ANG_W-1:0]  ang_s2;
	logic                       byp_s2;

	logic [RW-1:0]              sq_s3;
	logic signed [XW-1:0]       x_s3;
	logic signed [XW-1:0]       y_s3;
	logic [cve_pkg::ANG_W-1:0]  ang_s3;
	logic                       byp_s3;

	assign neg  = re_in[N-1];
	assign re_u = re_in;
	assign im_u = im_in;
	assign are_d = neg ? (~re_u + 1'b1) : re_u;
	assign aim_d = im_in[N-1] ? (~im_u + 1'b1) : im_u;

	assign rex = XW'(re_in);
	assign imx = XW'(im_in);
	assign x_d = (neg ? -rex : rex) <<< cve_pkg::GUARD_BITS;
	assign y_d = (neg ? -imx : imx) <<< cve_pkg::GUARD_BITS;

	// Samples on an axis take an exact angle, which the rotation stages pass on unchanged.
	always_comb begin
		if (im_in == '0) begin
			ang_d = neg ? cve_pkg::ANG_HALF : cve_pkg::ANG_ZERO;
			byp_d = 1'b1;
		end else if (re_in == '0) begin
			ang_d = im_in[N-1] ? cve_pkg::ANG_THREE_Q : cve_pkg::ANG_QUARTER;
			byp_d = 1'b1;
		end else begin
			ang_d = neg ? cve_pkg::ANG_HALF : cve_pkg::ANG_ZERO;
			byp_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			are_s1 <= are_d;
			aim_s1 <= aim_d;
			x_s1   <= x_d;
			y_s1   <= y_d;
			ang_s1 <= ang_d;
			byp_s1 <= byp_d;

			sqa_s2 <= RW'(are_s1) * RW'(are_s1);
			sqb_s2 <= RW'(aim_s1) * RW'(aim_s1);
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			ang_s2 <= ang_s1;
			byp_s2 <= byp_s1;

			sq_s3  <= sqa_s2 + sqb_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			ang_s3 <= ang_s2;
			byp_s3 <= byp_s2;
		end
	end

	assign sq_out  = sq_s3;
	assign x_out   = x_s3;
	assign y_out   = y_s3;
	assign ang_out = ang_s3;
	assign byp_out = byp_s3;

endmodule

>>> rtl/core/cve_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined square root
// Restoring digit-by-digit root, one result bit per stage, padded to a fixed
// latency so that it lines up with the vectoring pipeline.
// ----------------------------------------------------------------------------
module cve_sqrt #(
	parameter int SAMPLE_BITS = cve_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [2*SAMPLE_BITS-1:0]   rad_in,
	output logic [2*SAMPLE_BITS-1:0]   rad_out,
	output logic [SAMPLE_BITS-1:0]     root_out,
	output logic [SAMPLE_BITS:0]       rem_out
);

	localparam int N      = SAMPLE_BITS;
	localparam int RADW   = 2 * SAMPLE_BITS;
	localparam int STAGES = cve_pkg::CORDIC_ITERS;

	logic [RADW-1:0] rad_s  [STAGES];
	logic [N-1:0]    root_s [STAGES];
	logic [N:0]      rem_s  [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [RADW-1:0] rad_d;
		logic [N-1:0]    root_d;
		logic [N:0]      rem_d;

		if (k == 0) begin : g_first
			assign rad_d  = rad_in;
			assign root_d = '0;
			assign rem_d  = '0;
		end else begin : g_next
			assign rad_d  = rad_s[k-1];
			assign root_d = root_s[k-1];
			assign rem_d  = rem_s[k-1];
		end

		if (k < N) begin : g_iter
			logic [N+2:0] part;
			logic [N+2:0] trial;
			logic [N+2:0] diff;
			logic         ge;

			assign part  = {rem_d, rad_d[RADW-1-2*k -: 2]};
			assign trial = {1'b0, root_d, 2'b01};
			assign diff  = part - trial;
			assign ge    = (part >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k]  <= rad_d;
					root_s[k] <= {root_d[N-2:0], ge};
					rem_s[k]  <= ge ? diff[N:0] : part[N:0];
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k]  <= rad_d;
					root_s[k] <= root_d;
					rem_s[k]  <= rem_d;
				end
			end
		end
	end

	assign rad_out  = rad_s[STAGES-1];
	assign root_out = root_s[STAGES-1];
	assign rem_out  = rem_s[STAGES-1];

endmodule

>>> rtl/core/cve_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined vectoring unit
// One rotation per stage drives y towards zero and accumulates the angle as
// a fraction of a full turn.
// ----------------------------------------------------------------------------
module cve_cordic #(
	parameter int SAMPLE_BITS = cve_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              en,
	input  logic signed [SAMPLE_BITS+cve_pkg::GUARD_BITS+2:0] x_in,
	input  logic signed [SAMPLE_BITS+cve_pkg::GUARD_BITS+2:0] y_in,
	input  logic [cve_pkg::ANG_W-1:0]                         ang_in,
	input  logic                                              byp_in,
	output logic [cve_pkg::ANG_W-1:0]                         ang_out
);

	localparam int XW     = SAMPLE_BITS + cve_pkg::GUARD_BITS + 3;
	localparam int STAGES = cve_pkg::CORDIC_ITERS;

	logic signed [XW-1:0]      x_s   [STAGES];
	logic signed [XW-1:0]      y_s   [STAGES];
	logic [cve_pkg::ANG_W-1:0] ang_s [STAGES];
	logic                      byp_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic signed [XW-1:0]      x_d;
		logic signed [XW-1:0]      y_d;
		logic [cve_pkg::ANG_W-1:0] ang_d;
		logic                      byp_d;
		logic signed [XW-1:0]      x_sh;
		logic signed [XW-1:0]      y_sh;

		if (k == 0) begin : g_first
			assign x_d   = x_in;
			assign y_d   = y_in;
			assign ang_d = ang_in;
			assign byp_d = byp_in;
		end else begin : g_next
			assign x_d   = x_s[k-1];
			assign y_d   = y_s[k-1];
			assign ang_d = ang_s[k-1];
			assign byp_d = byp_s[k-1];
		end

		assign x_sh = x_d >>> k;
		assign y_sh = y_d >>> k;

		always_ff @(posedge clk) begin
			if (en) begin
				byp_s[k] <= byp_d;
				if (!y_d[XW-1]) begin
					x_s[k] <= x_d + y_sh;
					y_s[k] <= y_d - x_sh;
				end else begin
					x_s[k] <= x_d - y_sh;
					y_s[k] <= y_d + x_sh;
				end
				if (byp_d) begin
					ang_s[k] <= ang_d;
				end else if (!y_d[XW-1]) begin
					ang_s[k] <= ang_d + cve_pkg::TURN_TABLE[k];
				end else begin
					ang_s[k] <= ang_d - cve_pkg::TURN_TABLE[k];
				end
			end
		end
	end

	assign ang_out = ang_s[STAGES-1];

endmodule

>>> rtl/core/complex_value_extract_top.sv
// ----------------------------------------------------------------------------
// Complex value extract
// Returns the real part, imaginary part, rounded magnitude, squared magnitude
// or phase of one complex sample per beat.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata                     | tuser
//  s_*     | in  | re_part, im_part          | op
//  m_*     | out | value (33 bits, padded)   | bad_op
//
//  One beat is accepted per cycle while s_tready is high; a result is offered
//  after its input beat has passed three set-up stages, the 32 vectoring
//  stages and the output register.
//  The square root runs alongside and is padded to the same depth.
//  Reset is asynchronous and clears only valid and handshake state.
//  A two-entry output register absorbs one stalled beat; s_tready falls only
//  when both entries are full, and the whole pipeline then holds.
// ----------------------------------------------------------------------------
module complex_value_extract_top #(
	parameter int SAMPLE_BITS = cve_pkg::SAMPLE_BITS_DEF,
	parameter int ANGLE_STEPS = cve_pkg::ANGLE_STEPS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// re_part [SAMPLE_BITS-1:0], im_part above it, zero padding to whole bytes
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
	// op [2:0]
	input  logic [cve_pkg::OP_W-1:0]                s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// value [32:0], zero padding [39:33]
	output logic [cve_pkg::M_DATA_W-1:0]            m_tdata,
	// bad_op [0]
	output logic                                    m_tuser
);

	localparam int N     = SAMPLE_BITS;
	localparam int XW    = SAMPLE_BITS + cve_pkg::GUARD_BITS + 3;
	localparam int DEPTH = cve_pkg::PREP_STAGES + cve_pkg::CORDIC_ITERS;
	localparam logic [cve_pkg::ANG_W:0] HALF_STEP =
		(cve_pkg::ANG_W + 1)'(64'd1 << (cve_pkg::ANG_W - 1)) >> ANGLE_STEPS;

	logic                       en;
	logic signed [N-1:0]        re_in;
	logic signed [N-1:0]        im_in;

	logic [2*N-1:0]             sq_p;
	logic signed [XW-1:0]       x_p;
	logic signed [XW-1:0]       y_p;
	logic [cve_pkg::ANG_W-1:0]  ang_p;
	logic                       byp_p;

	logic [2*N-1:0]             sq_last;
	logic [N-1:0]               root_last;
	logic [N:0]                 rem_last;
	logic [cve_pkg::ANG_W-1:0]  ang_last;

	logic                       vld_s [DEPTH];
	logic [cve_pkg::OP_W-1:0]   op_s  [DEPTH];
	logic signed [N-1:0]        re_s  [DEPTH];
	logic signed [N-1:0]        im_s  [DEPTH];

	logic [N:0]                 mag;
	logic [cve_pkg::ANG_W:0]    ang_sum;
	logic [ANGLE_STEPS-1:0]     phase;
	logic [cve_pkg::VALUE_W-1:0] value_d;
	logic                       bad_d;
	logic                       take;

	logic                       out_valid_q;
	logic [cve_pkg::VALUE_W-1:0] out_value_q;
	logic                       out_bad_q;
	logic                       skid_valid_q;
	logic [cve_pkg::VALUE_W-1:0] skid_value_q;
	logic                       skid_bad_q;

	assign en       = !skid_valid_q;
	assign s_tready = en;
	assign re_in    = s_tdata[N-1:0];
	assign im_in    = s_tdata[2*N-1:N];

	cve_prep #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_prep (
		.clk     (clk),
		.en      (en),
		.re_in   (re_in),
		.im_in   (im_in),
		.sq_out  (sq_p),
		.x_out   (x_p),
		.y_out   (y_p),
		.ang_out (ang_p),
		.byp_out (byp_p)
	);

	cve_sqrt #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_sqrt (
		.clk      (clk),
		.en       (en),
		.rad_in   (sq_p),
		.rad_out  (sq_last),
		.root_out (root_last),
		.rem_out  (rem_last)
	);

	cve_cordic #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_cordic (
		.clk     (clk),
		.en      (en),
		.x_in    (x_p),
		.y_in    (y_p),
		.ang_in  (ang_p),
		.byp_in  (byp_p),
		.ang_out (ang_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int k = 1; k < DEPTH; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s[0] <= s_tuser;
			re_s[0] <= re_in;
			im_s[0] <= im_in;
			for (int k = 1; k < DEPTH; k++) begin
				op_s[k] <= op_s[k-1];
				re_s[k] <= re_s[k-1];
				im_s[k] <= im_s[k-1];
			end
		end
	end

	// The root rounds up when the remainder exceeds the root itself.
	assign mag     = {1'b0, root_last} + (N+1)'(rem_last > {1'b0, root_last});
	assign ang_sum = {1'b0, ang_last} + HALF_STEP;
	assign phase   = ang_sum[cve_pkg::ANG_W-1 -: ANGLE_STEPS];

	always_comb begin
		bad_d = 1'b0;
		case (op_s[DEPTH-1])
			cve_pkg::OP_REAL:   value_d = cve_pkg::VALUE_W'(re_s[DEPTH-1]);
			cve_pkg::OP_IMAG:   value_d = cve_pkg::VALUE_W'(im_s[DEPTH-1]);
			cve_pkg::OP_MAG:    value_d = cve_pkg::VALUE_W'(mag);
			cve_pkg::OP_MAG_SQ: value_d = cve_pkg::VALUE_W'(sq_last);
			cve_pkg::OP_PHASE:  value_d = cve_pkg::VALUE_W'(phase);
			default: begin
				value_d = '0;
				bad_d   = 1'b1;
			end
		endcase
	end

	assign take = en && vld_s[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (take) begin
			if (out_valid_q && !m_tready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_value_q <= skid_value_q;
				out_bad_q   <= skid_bad_q;
			end
		end else if (take) begin
			if (out_valid_q && !m_tready) begin
				skid_value_q <= value_d;
				skid_bad_q   <= bad_d;
			end else begin
				out_value_q <= value_d;
				out_bad_q   <= bad_d;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = cve_pkg::M_DATA_W'(out_value_q);
	assign m_tuser  = out_bad_q;

endmodule

>>> rtl/core/cve_checker.sv
// ----------------------------------------------------------------------------
// Complex value extract checker
// Port-level assertions on the result channel and the input back-pressure.
// ----------------------------------------------------------------------------
module cve_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [cve_pkg::M_DATA_W-1:0] m_tdata,
	input logic                         m_tuser
);

	// A stalled result beat keeps its value and flag.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result beat changed while stalled.");

	// An unknown op always returns zero.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("Flagged result carries a non-zero value.");

	// With the output empty the spare entry is empty too, so input is open.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input closed while no result is waiting.");

	// Input closes only after the output was stalled on the previous edge.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("Input closed without a stalled result.");

endmodule

bind complex_value_extract_top cve_checker u_cve_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
